[rtl/core/rc4x_pkg.sv]
// Shared types and constants for the extended ARCFOUR stream cipher.
// Holds the port beat structs, the action and operation codes and the queue command.
// No dependencies.
package rc4x_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SBOX_DEPTH  = 1 << BYTE_W;
  localparam int unsigned ROUND_W     = 4 * 3;
  localparam logic [ROUND_W-1:0] WARMUP_ROUNDS = ROUND_W'(3072);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_INIT      = 3'd0,
    ACT_FEED      = 3'd1,
    ACT_WARMUP    = 3'd2,
    ACT_KEYSTREAM = 3'd3,
    ACT_ENCRYPT   = 3'd4,
    ACT_DECRYPT   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_FEED,
    OP_WARMUP,
    OP_KEYSTREAM,
    OP_ENCRYPT,
    OP_DECRYPT
  } op_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_segment;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic              segment_end;
  } out_beat_t;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic              eos;
  } cmd_t;

endpackage

[rtl/core/arcfour_xor_add_stream_cipher.sv]
// Top level of the extended ARCFOUR stream cipher: front queue, engine, output register.
// Depends on rc4x_pkg, rc4x_front and rc4x_engine.
//
// Usage: one input beat (in_valid_i/in_ready_o, in_data_i) carries an action, a data
// byte and an end-of-segment mark; every beat returns exactly one output beat
// (out_valid_o/out_ready_i, out_data_o) in order, with the mark copied through.
// Actions: init, feed key byte, warmup (3072 steps, returns zero), keystream byte,
// encrypt ((p xor k1) + k2) and decrypt ((c - k2) xor k1); other codes return zero.
// Timing: a two-beat input queue decouples the port from the engine. A keystream
// step runs on the permutation memory with one read and one write port (two reads,
// two swap writes, one result read overlapped with the second write).
// Reset: the permutation reads as identity, i = j = 0, queue and output empty.
// Init clears the permutation to identity through per-entry valid bits.
// Stalls: when out_ready_i is low the result holds in the output register,
// the engine waits with its next result and the queue keeps taking beats
// until full, then in_ready_o drops.
module arcfour_xor_add_stream_cipher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rc4x_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rc4x_pkg::out_beat_t out_data_o
);
  import rc4x_pkg::*;

  logic      cmd_valid, cmd_pop;
  cmd_t      cmd;
  logic      res_valid, res_ready;
  out_beat_t res;
  logic      ovld_q;
  out_beat_t odata_q;

  rc4x_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rc4x_engine u_engine (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Take a new result when the output slot is empty or drains this cycle.
  assign res_ready = !ovld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      odata_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (res_ready) begin
      ovld_q <= res_valid;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

endmodule

[rtl/core/rc4x_front.sv]
// Front end: accepts input beats, decodes the action and queues commands.
// Depends on rc4x_pkg.
module rc4x_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rc4x_pkg::in_beat_t in_data_i,
  output logic              cmd_valid_o,
  output rc4x_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);
  import rc4x_pkg::*;

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_new;
  logic              push, pop;

  // Decode the action; unknown codes become a no-op that still returns a byte.
  always_comb begin
    cmd_new.data = in_data_i.data_byte;
    cmd_new.eos  = in_data_i.end_of_segment;
    unique case (in_data_i.action)
      ACT_INIT:      cmd_new.op = OP_INIT;
      ACT_FEED:      cmd_new.op = OP_FEED;
      ACT_WARMUP:    cmd_new.op = OP_WARMUP;
      ACT_KEYSTREAM: cmd_new.op = OP_KEYSTREAM;
      ACT_ENCRYPT:   cmd_new.op = OP_ENCRYPT;
      ACT_DECRYPT:   cmd_new.op = OP_DECRYPT;
      default:       cmd_new.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/rc4x_engine.sv]
// Back end: permutation memory, indices and the sequencer that runs key
// scheduling, keystream steps and the encrypt/decrypt combine. Depends on rc4x_pkg.
module rc4x_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  rc4x_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_valid_o,
  output rc4x_pkg::out_beat_t res_o,
  input  logic                res_ready_i
);
  import rc4x_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_FA   = 10'b00_0000_0010,
    ST_FB   = 10'b00_0000_0100,
    ST_FC   = 10'b00_0000_1000,
    ST_KA   = 10'b00_0001_0000,
    ST_KB   = 10'b00_0010_0000,
    ST_KC   = 10'b00_0100_0000,
    ST_KD   = 10'b00_1000_0000,
    ST_KE   = 10'b01_0000_0000,
    ST_PUSH = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [BYTE_W-1:0]  i_q, i_d, j_q, j_d;
  logic [BYTE_W-1:0]  si_q, si_d, sj_q, sj_d, k1_q, k1_d;
  logic [BYTE_W-1:0]  res_q, res_d, data_q, data_d;
  logic [ROUND_W-1:0] rounds_q, rounds_d;
  logic               second_q, second_d;
  logic               eos_q, eos_d;
  op_e                op_q, op_d;

  // Permutation memory; an entry not written since init reads as its address.
  logic [BYTE_W-1:0]     mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] vld_q;
  logic [BYTE_W-1:0]     rdata_q, raddr_q, bypd_q;
  logic                  rvld_q, byp_q;
  logic                  rd_en, we, clr_vld;
  logic [BYTE_W-1:0]     rd_addr, wa, wd, rd_val;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      raddr_q <= rd_addr;
      rvld_q  <= vld_q[rd_addr];
      byp_q   <= we && (wa == rd_addr);
      bypd_q  <= wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_vld) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[wa] <= 1'b1;
    end
  end

  // Same-cycle write wins over the stale array word.
  assign rd_val = byp_q ? bypd_q : (rvld_q ? rdata_q : raddr_q);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    si_d      = si_q;
    sj_d      = sj_q;
    k1_d      = k1_q;
    res_d     = res_q;
    data_d    = data_q;
    eos_d     = eos_q;
    op_d      = op_q;
    rounds_d  = rounds_q;
    second_d  = second_q;
    rd_en     = 1'b0;
    rd_addr   = i_q;
    we        = 1'b0;
    wa        = i_q;
    wd        = rd_val;
    clr_vld   = 1'b0;
    cmd_pop_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          data_d    = cmd_i.data;
          eos_d     = cmd_i.eos;
          second_d  = 1'b0;
          res_d     = '0;
          unique case (cmd_i.op)
            OP_INIT: begin
              clr_vld = 1'b1;
              i_d     = '0;
              j_d     = '0;
              state_d = ST_PUSH;
            end
            OP_FEED: state_d = ST_FA;
            OP_WARMUP: begin
              i_d      = '0;
              j_d      = '0;
              rounds_d = WARMUP_ROUNDS;
              state_d  = (WARMUP_ROUNDS == '0) ? ST_PUSH : ST_KA;
            end
            OP_KEYSTREAM, OP_ENCRYPT, OP_DECRYPT: state_d = ST_KA;
            default: state_d = ST_PUSH;
          endcase
        end
      end
      // Key feed: j += S[i] + key, advance i, then share the swap states.
      ST_FA: begin
        rd_en   = 1'b1;
        rd_addr = i_q;
        state_d = ST_FB;
      end
      ST_FB: begin
        j_d     = j_q + rd_val + data_q;
        i_d     = i_q + BYTE_W'(1);
        rd_en   = 1'b1;
        rd_addr = i_q + BYTE_W'(1);
        state_d = ST_FC;
      end
      ST_FC: begin
        si_d    = rd_val;
        rd_en   = 1'b1;
        rd_addr = j_q;
        state_d = ST_KC;
      end
      ST_KA: begin
        i_d     = i_q + BYTE_W'(1);
        rd_en   = 1'b1;
        rd_addr = i_q + BYTE_W'(1);
        state_d = ST_KB;
      end
      ST_KB: begin
        si_d    = rd_val;
        j_d     = j_q + rd_val;
        rd_en   = 1'b1;
        rd_addr = j_q + rd_val;
        state_d = ST_KC;
      end
      ST_KC: begin
        sj_d    = rd_val;
        we      = 1'b1;
        wa      = i_q;
        wd      = rd_val;
        state_d = ST_KD;
      end
      ST_KD: begin
        we      = 1'b1;
        wa      = j_q;
        wd      = si_q;
        rd_en   = 1'b1;
        rd_addr = si_q + sj_q;
        state_d = ST_KE;
      end
      // rd_val holds the keystream byte; either finish or start the next step.
      ST_KE: begin
        unique case (op_q)
          OP_WARMUP: begin
            rounds_d = rounds_q - ROUND_W'(1);
            if (rounds_q == ROUND_W'(1)) begin
              state_d = ST_PUSH;
            end else begin
              i_d     = i_q + BYTE_W'(1);
              rd_en   = 1'b1;
              rd_addr = i_q + BYTE_W'(1);
              state_d = ST_KB;
            end
          end
          OP_KEYSTREAM: begin
            res_d   = rd_val;
            state_d = ST_PUSH;
          end
          OP_ENCRYPT, OP_DECRYPT: begin
            if (!second_q) begin
              k1_d     = rd_val;
              second_d = 1'b1;
              i_d      = i_q + BYTE_W'(1);
              rd_en    = 1'b1;
              rd_addr  = i_q + BYTE_W'(1);
              state_d  = ST_KB;
            end else begin
              if (op_q == OP_ENCRYPT) begin
                res_d = (data_q ^ k1_q) + rd_val;
              end else begin
                res_d = (data_q - rd_val) ^ k1_q;
              end
              state_d = ST_PUSH;
            end
          end
          default: state_d = ST_PUSH;
        endcase
      end
      ST_PUSH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_valid_o       = (state_q == ST_PUSH);
  assign res_o.result_byte = res_q;
  assign res_o.segment_end = eos_q;

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    k1_q   <= k1_d;
    res_q  <= res_d;
    data_q <= data_d;
    eos_q  <= eos_d;
    op_q   <= op_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      rounds_q <= '0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      rounds_q <= rounds_d;
      second_q <= second_d;
    end
  end

endmodule
